// ----- src/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window switch debouncer package
// Shared widths, register map, event codes and interface types.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int WLEN_WIDTH  = 16;
  localparam int LEN_WIDTH   = (COUNT_WIDTH > WLEN_WIDTH) ? COUNT_WIDTH : WLEN_WIDTH;
  localparam int PADDR_WIDTH = 4;
  localparam int PDATA_WIDTH = 32;
  localparam int TDATA_WIDTH = 8;

  localparam logic [WLEN_WIDTH-1:0] WLEN_RST          = WLEN_WIDTH'(8);
  localparam logic                  PRESS_LEVEL_RST   = 1'b0;
  localparam logic                  DEFAULT_LEVEL_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_PRESS_LEVEL   = 2'd1,
    REG_DEFAULT_LEVEL = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [WLEN_WIDTH-1:0] window_length;
    logic                  active_level;
    logic                  init_level;
    logic                  load_default;
  } cfg_t;

  typedef struct packed {
    logic       window_done;
    logic       stable_level;
    logic [1:0] event_kind;
  } result_t;

endpackage

// ----- src/wsd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding window length, press level and default level.
// ----------------------------------------------------------------------------
module wsd_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsd_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [wsd_pkg::PDATA_WIDTH-1:0]  pwdata,
  output logic [wsd_pkg::PDATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  output wsd_pkg::cfg_t                    cfg
);
  import wsd_pkg::*;

  logic [WLEN_WIDTH-1:0] window_length;
  logic                  active_level;
  logic                  init_level;
  logic                  wr_en;
  reg_index_t            index;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign index  = reg_index_t'(paddr[PADDR_WIDTH-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RST;
      active_level  <= PRESS_LEVEL_RST;
      init_level    <= DEFAULT_LEVEL_RST;
    end else if (wr_en) begin
      case (index)
        REG_WINDOW_LENGTH: window_length <= pwdata[WLEN_WIDTH-1:0];
        REG_PRESS_LEVEL:   active_level  <= pwdata[0];
        REG_DEFAULT_LEVEL: init_level    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (index)
      REG_WINDOW_LENGTH: prdata = PDATA_WIDTH'(window_length);
      REG_PRESS_LEVEL:   prdata = PDATA_WIDTH'(active_level);
      REG_DEFAULT_LEVEL: prdata = PDATA_WIDTH'(init_level);
      default:           prdata = '0;
    endcase
  end

  assign cfg.window_length = window_length;
  assign cfg.active_level  = active_level;
  assign cfg.init_level    = pwdata[0];
  assign cfg.load_default  = wr_en && (index == REG_DEFAULT_LEVEL);

endmodule

// ----- src/wsd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window core; a default-level write also loads the debounced state.
// Sample counter, ones sum and debounced state, updated once per accepted beat.
// ----------------------------------------------------------------------------
module wsd_core (
  input  logic              clk,
  input  logic              rst,
  input  wsd_pkg::cfg_t     cfg,
  input  logic              accept,
  input  logic              sample_level,
  output wsd_pkg::result_t  result
);
  import wsd_pkg::*;

  localparam logic [LEN_WIDTH-1:0] CNT_MAX = LEN_WIDTH'({COUNT_WIDTH{1'b1}});

  logic [COUNT_WIDTH-1:0] sample_count;
  logic [COUNT_WIDTH-1:0] ones_sum;
  logic                   debounced_state;

  logic [COUNT_WIDTH-1:0] sample_count_next;
  logic [COUNT_WIDTH-1:0] ones_sum_next;
  logic                   debounced_state_next;
  logic [LEN_WIDTH-1:0]   wlen_ext;
  logic [LEN_WIDTH-1:0]   eff_len;
  logic                   done;
  logic                   uniform;
  logic                   level;
  event_kind_t            kind;

  always_comb begin
    wlen_ext = LEN_WIDTH'(cfg.window_length);
    if (wlen_ext == '0) begin
      eff_len = LEN_WIDTH'(1);
    end else if (wlen_ext > CNT_MAX) begin
      eff_len = CNT_MAX;
    end else begin
      eff_len = wlen_ext;
    end

    sample_count_next    = sample_count + COUNT_WIDTH'(1);
    ones_sum_next        = ones_sum + COUNT_WIDTH'(sample_level);
    done                 = LEN_WIDTH'(sample_count_next) >= eff_len;
    uniform              = 1'b0;
    level                = 1'b0;
    kind                 = EV_NONE;
    debounced_state_next = debounced_state;

    if (done) begin
      if (ones_sum_next == '0) begin
        uniform = 1'b1;
        level   = 1'b0;
      end else if (ones_sum_next == sample_count_next) begin
        uniform = 1'b1;
        level   = 1'b1;
      end
      sample_count_next = '0;
      ones_sum_next     = '0;
      if (uniform) begin
        if (level != debounced_state) begin
          kind = (level == cfg.active_level) ? EV_PRESS : EV_RELEASE;
        end
        debounced_state_next = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      ones_sum        <= '0;
      debounced_state <= DEFAULT_LEVEL_RST;
    end else if (cfg.load_default) begin
      debounced_state <= cfg.init_level;
    end else if (accept) begin
      sample_count    <= sample_count_next;
      ones_sum        <= ones_sum_next;
      debounced_state <= debounced_state_next;
    end
  end

  assign result.event_kind   = kind;
  assign result.stable_level = debounced_state_next;
  assign result.window_done  = done;

endmodule

// ----- src/wsd_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output stage
// Result register on the master side; takes a new beat whenever it is empty
// or its current beat leaves in the same cycle.
// ----------------------------------------------------------------------------
module wsd_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wsd_pkg::result_t                 in_result,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wsd_pkg::TDATA_WIDTH-1:0]  m_tdata
);
  import wsd_pkg::*;

  logic    out_valid;
  result_t out_result;

  assign in_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= in_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_WIDTH'(out_result);

endmodule

// ----- src/window_switch_debouncer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window switch debouncer
// Decides a stable switch level from windows of raw samples and reports
// press and release events.
// ----------------------------------------------------------------------------
// Each slave beat carries one raw pin sample. Every accepted sample yields
// exactly one master beat with the event kind, the debounced level after
// that sample and a flag that marks the sample closing a window.
// A window closes when its sample count reaches the window length; if all
// samples in it agree, that level becomes the debounced level.
// A master beat follows its accepted slave beat in the next cycle, and
// one beat is taken per cycle unless stalled; a single register sets both.
// When the receiver stalls, the held beat stays on m_tdata and s_tready
// drops until it is taken; the result register frees in the cycle it leaves.
// Reset clears the counters, loads the debounced level with 1, sets the
// window length to 8, press level to 0 and default level to 1, and empties
// the result register. Registers: window length at 0x0, press level at
// 0x4, default level at 0x8; writing the default level also loads the
// debounced level. Write registers only while no beat is in flight.
// ----------------------------------------------------------------------------
module window_switch_debouncer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wsd_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [wsd_pkg::PDATA_WIDTH-1:0]  pwdata,
  output logic [wsd_pkg::PDATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: [0] sample_level, [7:1] zero
  input  logic [wsd_pkg::TDATA_WIDTH-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: [1:0] event_kind, [2] stable_level, [3] window_done, [7:4] zero
  output logic [wsd_pkg::TDATA_WIDTH-1:0]  m_tdata
);
  import wsd_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  wsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .sample_level (s_tdata[0]),
    .result       (result)
  );

  wsd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_result (result),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted sample produced no result beat");

  a_event_needs_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != EV_NONE) |-> m_tdata[3])
    else $error("event reported without a completed window");

  a_event_code_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == EV_NONE) || (m_tdata[1:0] == EV_PRESS)
      || (m_tdata[1:0] == EV_RELEASE))
    else $error("illegal event code on output");

endmodule

// ----- test/tb_window_switch_debouncer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window switch debouncer testbench
// Sends raw pin samples over the slave stream and writes the window length,
// press level and default level over APB. An in-bench model of the window
// logic predicts every master beat, and a checker compares each one field by
// field. Both stream sides idle in random bursts, and one long receiver stall
// makes the block fill up and hold off its input.
// ----------------------------------------------------------------------------
module tb_window_switch_debouncer;
  import wsd_pkg::*;

  localparam logic [PADDR_WIDTH-1:0] ADDR_WINDOW_LENGTH = PADDR_WIDTH'(REG_WINDOW_LENGTH) << 2;
  localparam logic [PADDR_WIDTH-1:0] ADDR_PRESS_LEVEL   = PADDR_WIDTH'(REG_PRESS_LEVEL) << 2;
  localparam logic [PADDR_WIDTH-1:0] ADDR_DEFAULT_LEVEL = PADDR_WIDTH'(REG_DEFAULT_LEVEL) << 2;
  localparam logic [PADDR_WIDTH-1:0] ADDR_UNMAPPED      = 4'hC;
  localparam int LONG_HOLD      = 200;
  localparam int RANDOM_SAMPLES = 1480;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // s_tdata: [0] sample_level, [7:1] zero
  logic [TDATA_WIDTH-1:0] s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // m_tdata: [1:0] event_kind, [2] stable_level, [3] window_done, [7:4] zero
  logic [TDATA_WIDTH-1:0] m_tdata;

  // Model state of the debouncer.
  logic [WLEN_WIDTH-1:0]  win_len = WLEN_RST;
  logic                   press_lvl = PRESS_LEVEL_RST;
  logic [COUNT_WIDTH-1:0] samp_cnt = '0;
  logic [COUNT_WIDTH-1:0] ones_cnt = '0;
  logic                   stable = DEFAULT_LEVEL_RST;

  result_t beat_q[$];
  int      errors = 0;
  int      samples_sent = 0;
  int      beats_checked = 0;
  int      windows_closed = 0;
  int      presses = 0;
  int      releases = 0;
  int      cfg_writes = 0;

  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_gap_left = 0;

  window_switch_debouncer uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  function automatic result_t debounce_step(input logic lvl);
    result_t r;
    logic [COUNT_WIDTH-1:0] eff;
    logic level;
    eff = (win_len == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(win_len);
    ones_cnt = ones_cnt + COUNT_WIDTH'(lvl);
    samp_cnt = samp_cnt + COUNT_WIDTH'(1);
    r.event_kind = EV_NONE;
    r.window_done = 1'b0;
    if (samp_cnt >= eff) begin
      r.window_done = 1'b1;
      if (ones_cnt == '0 || ones_cnt == samp_cnt) begin
        level = (ones_cnt != '0);
        if (level != stable) begin
          r.event_kind = (level == press_lvl) ? EV_PRESS : EV_RELEASE;
        end
        stable = level;
      end
      samp_cnt = '0;
      ones_cnt = '0;
    end
    r.stable_level = stable;
    return r;
  endfunction

  function automatic void apply_reg(input logic [PADDR_WIDTH-1:0] addr,
                                    input logic [PDATA_WIDTH-1:0] data);
    case (addr)
      ADDR_WINDOW_LENGTH: begin
        win_len = data[WLEN_WIDTH-1:0];
      end
      ADDR_PRESS_LEVEL: begin
        press_lvl = data[0];
      end
      ADDR_DEFAULT_LEVEL: begin
        stable = data[0];
      end
      default: begin
      end
    endcase
  endfunction

  task automatic write_reg(input logic [PADDR_WIDTH-1:0] addr,
                           input logic [PDATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(addr, data);
    cfg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(input logic lvl);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TDATA_WIDTH-1){1'b0}}, lvl};
    do @(posedge clk); while (!s_tready);
    beat_q.push_back(debounce_step(lvl));
    samples_sent++;
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_sample(lvl);
  endtask

  // Lets the block go idle so that registers can be written safely.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left <= rx_gap_left - 1;
      m_tready <= 1'b0;
    end else if (rx_idling && $urandom_range(0, 7) == 0) begin
      rx_gap_left <= $urandom_range(0, 17);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic report(input string field, input int exp_val, input int act_val);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[3:0]);
      if (beat_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual 0x%02h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = beat_q.pop_front();
        beats_checked++;
        if (exp_r.window_done) windows_closed++;
        if (exp_r.event_kind == EV_PRESS) presses++;
        if (exp_r.event_kind == EV_RELEASE) releases++;
        if (got.event_kind != exp_r.event_kind) begin
          report("event_kind", int'(exp_r.event_kind), int'(got.event_kind));
        end
        if (got.stable_level != exp_r.stable_level) begin
          report("stable_level", int'(exp_r.stable_level), int'(got.stable_level));
        end
        if (got.window_done != exp_r.window_done) begin
          report("window_done", int'(exp_r.window_done), int'(got.window_done));
        end
        if (m_tdata[7:4] != 4'h0) begin
          report("padding", 0, int'(m_tdata[7:4]));
        end
      end
    end
  end

  task automatic test_directed;
    // Eight zeros against the reset level of one give a press.
    send_run(1'b0, 8);
    drain();
    // A zero length acts as one; upper register bits are ignored.
    write_reg(ADDR_WINDOW_LENGTH, 32'hFFFF_0000);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    drain();
    write_reg(ADDR_WINDOW_LENGTH, 32'h0000_0003);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    drain();
    write_reg(ADDR_PRESS_LEVEL, 32'hABCD_0001);
    send_run(1'b1, 3);
    drain();
    write_reg(ADDR_DEFAULT_LEVEL, 32'hFFFF_FFFE);
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_run(1'b0, 3);
    drain();
    // Shorten the window after five samples; the next one closes it.
    write_reg(ADDR_WINDOW_LENGTH, 32'h0000_0008);
    send_run(1'b1, 5);
    drain();
    write_reg(ADDR_WINDOW_LENGTH, 32'h0000_0002);
    send_sample(1'b1);
    drain();
  endtask

  task automatic random_config;
    logic [PDATA_WIDTH-1:0] d;
    logic [WLEN_WIDTH-1:0] len;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = WLEN_WIDTH'(1);
      8: len = WLEN_WIDTH'($urandom_range(7, 20));
      9: len = WLEN_WIDTH'($urandom_range(21, 40));
      default: len = WLEN_WIDTH'($urandom_range(2, 6));
    endcase
    d = $urandom;
    d[WLEN_WIDTH-1:0] = len;
    write_reg(ADDR_WINDOW_LENGTH, d);
    write_reg(ADDR_PRESS_LEVEL, $urandom);
    if ($urandom_range(0, 1)) write_reg(ADDR_DEFAULT_LEVEL, $urandom);
    if ($urandom_range(0, 7) == 0) write_reg(ADDR_UNMAPPED, $urandom);
  endtask

  task automatic test_random;
    int phase_end;
    int eff;
    while (samples_sent < RANDOM_SAMPLES) begin
      drain();
      random_config();
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      eff = (win_len == '0) ? 1 : int'(win_len);
      phase_end = samples_sent + $urandom_range(60, 140);
      while (samples_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          send_run(1'($urandom_range(0, 1)), $urandom_range(1, 3 * eff + 2));
        end else begin
          repeat ($urandom_range(1, 10)) send_sample(1'($urandom_range(0, 1)));
        end
      end
    end
    drain();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  task automatic test_backpressure;
    write_reg(ADDR_WINDOW_LENGTH, 32'h0000_0003);
    hold_requests++;
    repeat (24) send_sample(1'($urandom_range(0, 1)));
    drain();
  endtask

  task automatic test_no_idle;
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    // A long window closes on its last sample; upper register bits are ignored.
    write_reg(ADDR_DEFAULT_LEVEL, 32'h0000_0000);
    write_reg(ADDR_WINDOW_LENGTH, 32'hFFFF_0040);
    send_run(1'b1, 64);
    drain();
    write_reg(ADDR_WINDOW_LENGTH, 32'h0000_0004);
    repeat (50) send_run(1'($urandom_range(0, 1)), $urandom_range(1, 6));
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    repeat (5) @(posedge clk);
    $display("Covered %0d samples, %0d beats checked, %0d register writes.",
             samples_sent, beats_checked, cfg_writes);
    $display("Windows closed: %0d, presses: %0d, releases: %0d.",
             windows_closed, presses, releases);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d beats still expected.", beat_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
